FILE: design/bitmap_pixel_unpacker_unit_assert.svh
// Assertion macros for the bitmap pixel unpacker checker.
`ifndef BITMAP_PIXEL_UNPACKER_UNIT_ASSERT_SVH
`define BITMAP_PIXEL_UNPACKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpu_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_DEPTH_MODE    = 3'd2,
        CFG_ROWS_TOP_DOWN = 3'd3,
        CFG_PALETTE_COUNT = 3'd4
    } cfg_index_t;

    localparam logic [2:0] DEPTH_1BPP  = 3'd0;
    localparam logic [2:0] DEPTH_4BPP  = 3'd1;
    localparam logic [2:0] DEPTH_8BPP  = 3'd2;
    localparam logic [2:0] DEPTH_16BPP = 3'd3;
    localparam logic [2:0] DEPTH_24BPP = 3'd4;
    localparam logic [2:0] DEPTH_32BPP = 3'd5;

    localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] argb;
        logic        last;
        logic        done;
    } pix_t;

    // c * 255 / 31 as c * 8 + floor(c * 7 / 31), reciprocal 265 / 8192
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [7:0]  seven;
        logic [15:0] scaled;
        seven  = 8'(c) * 8'd7;
        scaled = 16'(seven) * 16'd265;
        return {c, 3'b000} + 8'(scaled[15:13]);
    endfunction

endpackage

`default_nettype wire

FILE: design/bitmap_pixel_unpacker_unit.sv
// Uncompressed bitmap pixel decoder. Palette writes and raw pixel bytes share one input
// channel; pixels leave as RGBA with column and row. 8, 16, 24 and 32-bit data and row
// padding take one byte per cycle while the output does not stall. A 4bpp byte holds the
// unpacker for up to 2 pixels and a 1bpp byte for up to 8 pixels, one pixel per cycle
// while the output does not stall, set by the single read port of the palette RAM. A
// pixel passes the unpacker, palette read and output register after its last byte is
// accepted. The palette has no reset; entries must be written before they are indexed.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_pixel_unpacker_unit #(
    parameter int MAX_DIMENSION = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [bpu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bpu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          action,
    input  wire logic [7:0]                    palette_slot,
    input  wire logic [23:0]                   palette_rgb,
    input  wire logic [7:0]                    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [11:0]                        pixel_x,
    output logic [11:0]                        pixel_y,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [7:0]                         alpha,
    output logic                               last_of_byte,
    output logic                               image_done
);

    localparam int          PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam logic [12:0] MAX_DIM = 13'(MAX_DIMENSION);
    localparam logic [8:0]  PAL_MAX = 9'(PALETTE_DEPTH);

    // configuration
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [2:0]  depth_reg, depth_next;
    logic        top_down_reg, top_down_next;
    logic [8:0]  pal_count_reg, pal_count_next;

    // stream position
    logic [14:0] rbp_reg, rbp_next;
    logic [11:0] row_reg, row_next;
    logic [11:0] col_reg, col_next;
    logic [23:0] pend_reg, pend_next;
    logic [1:0]  phase_reg, phase_next;

    // unpacker stage
    logic        s0_valid_reg, s0_valid_next;
    logic [2:0]  s0_i_reg, s0_i_next;
    logic [3:0]  s0_n_reg;
    logic [7:0]  s0_byte_reg;
    logic [2:0]  s0_mode_reg;
    logic [11:0] s0_col_reg;
    logic [11:0] s0_y_reg;
    logic        s0_last_row_reg;
    logic [31:0] s0_argb_reg;

    // palette read stage and output register
    logic            s1_valid_reg, s1_valid_next;
    bpu_pkg::pix_t   s1_pix_reg;
    logic            s1_use_ram_reg;
    logic            s2_valid_reg, s2_valid_next;
    bpu_pkg::pix_t   s2_pix_reg;

    logic [12:0] eff_w, eff_h;
    logic [17:0] row_bits;
    logic [17:0] words;
    logic [15:0] data_len, row_len;

    logic        acc, acc_data, acc_pal;
    logic        in_data, col_open;
    logic [12:0] col_room;
    logic [2:0]  need;
    logic [23:0] px;
    logic [3:0]  pix_n;
    logic [23:0] pend_dec;
    logic [1:0]  phase_dec;
    logic [31:0] direct_argb;
    logic [14:0] rbp_inc;
    logic        row_end;
    logic [12:0] y_mirror;
    logic [11:0] y_out;
    logic        last_row;

    logic        s2_free, s1_adv, s1_free, s0_emit, s0_done;
    logic [11:0] pix_col;
    logic [7:0]  pal_idx;
    logic        pal_mode;
    logic [8:0]  pal_cnt;
    logic        use_ram;
    bpu_pkg::pix_t s0_pix;
    bpu_pkg::pix_t s1_out;
    logic [23:0] ram_rdata;
    logic        ram_we;

    // effective geometry
    always_comb
    begin
        if (width_reg == 13'd0)
        begin
            eff_w = 13'd1;
        end
        else if (width_reg > MAX_DIM)
        begin
            eff_w = MAX_DIM;
        end
        else
        begin
            eff_w = width_reg;
        end
        if (height_reg == 13'd0)
        begin
            eff_h = 13'd1;
        end
        else if (height_reg > MAX_DIM)
        begin
            eff_h = MAX_DIM;
        end
        else
        begin
            eff_h = height_reg;
        end
        case (depth_reg)
            bpu_pkg::DEPTH_1BPP:  row_bits = 18'(eff_w);
            bpu_pkg::DEPTH_4BPP:  row_bits = 18'(eff_w) << 2;
            bpu_pkg::DEPTH_16BPP: row_bits = 18'(eff_w) << 4;
            bpu_pkg::DEPTH_24BPP: row_bits = (18'(eff_w) << 4) + (18'(eff_w) << 3);
            bpu_pkg::DEPTH_32BPP: row_bits = 18'(eff_w) << 5;
            default:              row_bits = 18'(eff_w) << 3;
        endcase
        data_len = 16'((row_bits + 18'd7) >> 3);
        words    = (row_bits + 18'd31) >> 5;
        row_len  = {words[13:0], 2'b00};
    end

    assign acc      = in_valid && in_ready;
    assign acc_data = acc && action;
    assign acc_pal  = acc && !action;

    // byte decode
    always_comb
    begin
        in_data     = {1'b0, rbp_reg} < data_len;
        col_open    = {1'b0, col_reg} < eff_w;
        col_room    = eff_w - {1'b0, col_reg};
        px          = pend_reg | {data_byte, 8'h00};
        pix_n       = 4'd0;
        pend_dec    = pend_reg;
        phase_dec   = phase_reg;
        direct_argb = bpu_pkg::OPAQUE_BLACK;
        case (depth_reg)
            bpu_pkg::DEPTH_16BPP: need = 3'd2;
            bpu_pkg::DEPTH_24BPP: need = 3'd3;
            default:              need = 3'd4;
        endcase
        if (in_data)
        begin
            case (depth_reg) inside
                bpu_pkg::DEPTH_1BPP:
                begin
                    if (col_open)
                    begin
                        pix_n = (col_room < 13'd8) ? 4'(col_room) : 4'd8;
                    end
                end
                bpu_pkg::DEPTH_4BPP:
                begin
                    if (col_open)
                    begin
                        pix_n = (col_room < 13'd2) ? 4'(col_room) : 4'd2;
                    end
                end
                bpu_pkg::DEPTH_16BPP, bpu_pkg::DEPTH_24BPP, bpu_pkg::DEPTH_32BPP:
                begin
                    if (({1'b0, phase_reg} + 3'd1) < need)
                    begin
                        pend_dec  = pend_reg | (24'(data_byte) << {phase_reg, 3'b000});
                        phase_dec = phase_reg + 2'd1;
                    end
                    else
                    begin
                        case (depth_reg)
                            bpu_pkg::DEPTH_16BPP:
                                direct_argb = {8'hFF, bpu_pkg::expand5(px[14:10]),
                                               bpu_pkg::expand5(px[9:5]),
                                               bpu_pkg::expand5(px[4:0])};
                            bpu_pkg::DEPTH_24BPP:
                                direct_argb = {8'hFF, data_byte, pend_reg[15:0]};
                            default:
                                direct_argb = {data_byte, pend_reg};
                        endcase
                        pend_dec  = 24'd0;
                        phase_dec = 2'd0;
                        pix_n     = {3'd0, col_open};
                    end
                end
                default:
                begin
                    pix_n = 4'd1;
                end
            endcase
        end
        y_mirror = eff_h - 13'd1 - {1'b0, row_reg};
        y_out    = top_down_reg ? row_reg : y_mirror[11:0];
        last_row = ({1'b0, row_reg} + 13'd1) == eff_h;
        rbp_inc  = rbp_reg + 15'd1;
        row_end  = {1'b0, rbp_inc} >= row_len;
    end

    // handshake flow
    assign s2_free  = !s2_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign s0_emit  = s0_valid_reg && s1_free;
    assign s0_done  = s0_emit && ({1'b0, s0_i_reg} == (s0_n_reg - 4'd1));
    assign in_ready = !s0_valid_reg || s0_done;

    // per-pixel unpack
    always_comb
    begin
        pix_col = s0_col_reg + 12'(s0_i_reg);
        case (s0_mode_reg)
            bpu_pkg::DEPTH_1BPP: pal_idx = {7'd0, s0_byte_reg[3'd7 - s0_i_reg]};
            bpu_pkg::DEPTH_4BPP: pal_idx = s0_i_reg[0] ? {4'd0, s0_byte_reg[3:0]}
                                                       : {4'd0, s0_byte_reg[7:4]};
            default:             pal_idx = s0_byte_reg;
        endcase
        pal_mode = (s0_mode_reg == bpu_pkg::DEPTH_1BPP) ||
                   (s0_mode_reg == bpu_pkg::DEPTH_4BPP) ||
                   (s0_mode_reg == bpu_pkg::DEPTH_8BPP);
        pal_cnt  = (pal_count_reg > PAL_MAX) ? PAL_MAX : pal_count_reg;
        use_ram  = pal_mode && ({1'b0, pal_idx} < pal_cnt);
        s0_pix.x    = pix_col;
        s0_pix.y    = s0_y_reg;
        s0_pix.argb = pal_mode ? bpu_pkg::OPAQUE_BLACK : s0_argb_reg;
        s0_pix.last = {1'b0, s0_i_reg} == (s0_n_reg - 4'd1);
        s0_pix.done = s0_last_row_reg && (({1'b0, pix_col} + 13'd1) == eff_w);
        s1_out      = s1_pix_reg;
        if (s1_use_ram_reg)
        begin
            s1_out.argb = {8'hFF, ram_rdata};
        end
    end

    assign ram_we = acc_pal && ({1'b0, palette_slot} < PAL_MAX);

    bpu_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (palette_slot[PAL_AW-1:0]),
        .wdata (palette_rgb),
        .re    (s0_emit && use_ram),
        .raddr (pal_idx[PAL_AW-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        width_next     = width_reg;
        height_next    = height_reg;
        depth_next     = depth_reg;
        top_down_next  = top_down_reg;
        pal_count_next = pal_count_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bpu_pkg::CFG_IMAGE_WIDTH:   width_next     = cfg_data;
                bpu_pkg::CFG_IMAGE_HEIGHT:  height_next    = cfg_data;
                bpu_pkg::CFG_DEPTH_MODE:    depth_next     = cfg_data[2:0];
                bpu_pkg::CFG_ROWS_TOP_DOWN: top_down_next  = cfg_data[0];
                bpu_pkg::CFG_PALETTE_COUNT: pal_count_next = cfg_data[8:0];
                default:
                begin
                end
            endcase
        end

        rbp_next   = rbp_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        pend_next  = pend_reg;
        phase_next = phase_reg;
        if (acc_data)
        begin
            if (row_end)
            begin
                rbp_next   = 15'd0;
                col_next   = 12'd0;
                pend_next  = 24'd0;
                phase_next = 2'd0;
                row_next   = (({1'b0, row_reg} + 13'd1) >= eff_h) ? 12'd0 : row_reg + 12'd1;
            end
            else
            begin
                rbp_next   = rbp_inc;
                col_next   = col_reg + 12'(pix_n);
                pend_next  = pend_dec;
                phase_next = phase_dec;
            end
        end

        s0_valid_next = s0_valid_reg;
        s0_i_next     = s0_i_reg;
        if (s0_emit)
        begin
            s0_i_next = s0_i_reg + 3'd1;
        end
        if (s0_done)
        begin
            s0_valid_next = 1'b0;
        end
        if (acc_data && (pix_n != 4'd0))
        begin
            s0_valid_next = 1'b1;
            s0_i_next     = 3'd0;
        end

        s1_valid_next = s1_valid_reg;
        if (s0_emit)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 13'd1;
            height_reg    <= 13'd1;
            depth_reg     <= bpu_pkg::DEPTH_8BPP;
            top_down_reg  <= 1'b0;
            pal_count_reg <= 9'd0;
            rbp_reg       <= 15'd0;
            row_reg       <= 12'd0;
            col_reg       <= 12'd0;
            pend_reg      <= 24'd0;
            phase_reg     <= 2'd0;
            s0_valid_reg  <= 1'b0;
            s0_i_reg      <= 3'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            depth_reg     <= depth_next;
            top_down_reg  <= top_down_next;
            pal_count_reg <= pal_count_next;
            rbp_reg       <= rbp_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            pend_reg      <= pend_next;
            phase_reg     <= phase_next;
            s0_valid_reg  <= s0_valid_next;
            s0_i_reg      <= s0_i_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (acc_data && (pix_n != 4'd0))
        begin
            s0_n_reg        <= pix_n;
            s0_byte_reg     <= data_byte;
            s0_mode_reg     <= depth_reg;
            s0_col_reg      <= col_reg;
            s0_y_reg        <= y_out;
            s0_last_row_reg <= last_row;
            s0_argb_reg     <= direct_argb;
        end
        if (s0_emit)
        begin
            s1_pix_reg     <= s0_pix;
            s1_use_ram_reg <= use_ram;
        end
        if (s1_adv)
        begin
            s2_pix_reg <= s1_out;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign pixel_x      = s2_pix_reg.x;
    assign pixel_y      = s2_pix_reg.y;
    assign alpha        = s2_pix_reg.argb[31:24];
    assign red          = s2_pix_reg.argb[23:16];
    assign green        = s2_pix_reg.argb[15:8];
    assign blue         = s2_pix_reg.argb[7:0];
    assign last_of_byte = s2_pix_reg.last;
    assign image_done   = s2_pix_reg.done;

endmodule

`default_nettype wire

FILE: design/bpu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/bpu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_pixel_unpacker_unit_assert.svh"

module bpu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_write,
    input wire logic [2:0]  cfg_index,
    input wire logic [12:0] cfg_data,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        action,
    input wire logic [7:0]  palette_slot,
    input wire logic [23:0] palette_rgb,
    input wire logic [7:0]  data_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [11:0] pixel_x,
    input wire logic [11:0] pixel_y,
    input wire logic [7:0]  red,
    input wire logic [7:0]  green,
    input wire logic [7:0]  blue,
    input wire logic [7:0]  alpha,
    input wire logic        last_of_byte,
    input wire logic        image_done
);

    // stalled transaction holds
    `BPU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha) && $stable(last_of_byte) && $stable(image_done), "output transaction changed while stalled")

    // final pixel of the image closes its byte
    `BPU_ASSERT_IMP(a_done_last, clk, rst_n, out_valid && image_done, last_of_byte, "image_done without last_of_byte")

    // pixels of one byte follow without a gap
    `BPU_ASSERT_NEXT(a_byte_burst, clk, rst_n, out_valid && out_ready && !last_of_byte, out_valid, "gap inside the pixels of one byte")

    // pixels of one byte are adjacent in one row
    `BPU_ASSERT_NEXT(a_byte_adjacent, clk, rst_n, out_valid && out_ready && !last_of_byte, (pixel_x == $past(pixel_x) + 12'd1) && (pixel_y == $past(pixel_y)), "pixels of one byte not adjacent")

endmodule

bind bitmap_pixel_unpacker_unit bpu_checker u_bpu_checker (.*);

`default_nettype wire

FILE: bench/bitmap_pixel_unpacker_unit_test.sv
`timescale 1ns / 1ps

module bitmap_pixel_unpacker_unit_test;
    import bpu_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 460;
    localparam int REPORT_LINES  = 100;

    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_PIXEL   = 1'b1;

    localparam logic [2:0] DEPTH_UNSUPPORTED = 3'd6;
    localparam logic [2:0] DEPTH_RESERVED    = 3'd7;

    typedef struct packed {
        logic        action;
        logic [7:0]  slot;
        logic [23:0] rgb;
        logic [7:0]  data;
    } stream_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   action = 1'b0;
    logic [7:0]             palette_slot = '0;
    logic [23:0]            palette_rgb = '0;
    logic [7:0]             data_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [11:0]            pixel_x;
    logic [11:0]            pixel_y;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [7:0]             alpha;
    logic                   last_of_byte;
    logic                   image_done;

    // shadow of the configuration and of the decode state
    logic [12:0] shadow_width = 13'd1;
    logic [12:0] shadow_height = 13'd1;
    logic [2:0]  shadow_mode = DEPTH_8BPP;
    logic        shadow_top_down = 1'b0;
    logic [8:0]  shadow_count = '0;
    logic [23:0] palette_copy [0:255];
    logic [14:0] row_pos = '0;
    logic [11:0] row_num = '0;
    logic [11:0] column = '0;
    logic [23:0] partial = '0;
    logic [1:0]  partial_bytes = '0;

    stream_item_t stream_items[$];
    pix_t         pixels_due[$];
    pix_t         step_pixels[$];

    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    logic in_taken = 1'b0;
    logic hold_sender = 1'b0;
    logic steady = 1'b0;

    bitmap_pixel_unpacker_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .palette_slot (palette_slot),
        .palette_rgb  (palette_rgb),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .last_of_byte (last_of_byte),
        .image_done   (image_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int bits_per_pixel(logic [2:0] mode);
        case (mode)
            DEPTH_1BPP:  return 1;
            DEPTH_4BPP:  return 4;
            DEPTH_16BPP: return 16;
            DEPTH_24BPP: return 24;
            DEPTH_32BPP: return 32;
            default:     return 8;
        endcase
    endfunction

    function automatic int clamp_size(logic [12:0] v);
        if (v == 13'd0)
            return 1;
        if (v > 13'd4096)
            return 4096;
        return int'(v);
    endfunction

    function automatic logic [31:0] palette_color(int idx);
        int limit;
        limit = (shadow_count > 9'd256) ? 256 : int'(shadow_count);
        if (idx >= limit)
            return OPAQUE_BLACK;
        return {8'hFF, palette_copy[idx]};
    endfunction

    function automatic logic [7:0] widen5(logic [4:0] c);
        return 8'((int'(c) * 255) / 31);
    endfunction

    function automatic void add_pixel(logic [31:0] argb, int w, int h);
        pix_t p;
        int   y;
        y = shadow_top_down ? int'(row_num) : h - 1 - int'(row_num);
        p.x = column;
        p.y = y[11:0];
        p.argb = argb;
        p.last = 1'b0;
        p.done = (int'(column) + 1 == w) && (int'(row_num) + 1 == h);
        step_pixels.push_back(p);
        column = column + 12'd1;
    endfunction

    function automatic void unpack_item(stream_item_t item);
        int          w;
        int          h;
        int          bpp;
        int          data_len;
        int          row_len;
        int          need;
        logic [2:0]  mode;
        logic [7:0]  b;
        logic [15:0] word;
        logic [31:0] argb;
        if (item.action == ACT_PALETTE)
        begin
            palette_copy[item.slot] = item.rgb;
            return;
        end
        w = clamp_size(shadow_width);
        h = clamp_size(shadow_height);
        mode = shadow_mode;
        bpp = bits_per_pixel(mode);
        data_len = (w * bpp + 7) / 8;
        row_len = ((w * bpp + 31) / 32) * 4;
        b = item.data;
        step_pixels.delete();
        if (int'(row_pos) < data_len)
        begin
            if (mode == DEPTH_1BPP || mode == DEPTH_4BPP)
            begin
                for (int i = 0; i < 8 / bpp && int'(column) < w; i++)
                    add_pixel(palette_color((mode == DEPTH_1BPP) ? int'(b[7 - i]) :
                                            ((i == 0) ? int'(b[7:4]) : int'(b[3:0]))), w, h);
            end
            else if (mode == DEPTH_8BPP)
                add_pixel(palette_color(int'(b)), w, h);
            else if (bpp == 8)
                add_pixel(OPAQUE_BLACK, w, h);
            else
            begin
                need = bpp / 8;
                if (int'(partial_bytes) + 1 < need)
                begin
                    partial = partial | (24'(b) << (8 * partial_bytes));
                    partial_bytes = partial_bytes + 2'd1;
                end
                else
                begin
                    if (mode == DEPTH_16BPP)
                    begin
                        word = partial[15:0] | {b, 8'h00};
                        argb = {8'hFF, widen5(word[14:10]), widen5(word[9:5]),
                                widen5(word[4:0])};
                    end
                    else if (mode == DEPTH_24BPP)
                        argb = {8'hFF, b, partial[15:0]};
                    else
                        argb = {b, partial};
                    partial = '0;
                    partial_bytes = '0;
                    if (int'(column) < w)
                        add_pixel(argb, w, h);
                end
            end
        end
        row_pos = row_pos + 15'd1;
        if (int'(row_pos) >= row_len)
        begin
            row_pos = '0;
            column = '0;
            partial = '0;
            partial_bytes = '0;
            if (int'(row_num) + 1 >= h)
                row_num = '0;
            else
                row_num = row_num + 12'd1;
        end
        if (step_pixels.size() > 0)
            step_pixels[step_pixels.size() - 1].last = 1'b1;
        foreach (step_pixels[i])
            pixels_due.push_back(step_pixels[i]);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic void queue_byte(logic [7:0] b);
        stream_item_t item;
        item.action = ACT_PIXEL;
        item.slot = 8'($urandom);
        item.rgb = 24'($urandom);
        item.data = b;
        stream_items.push_back(item);
    endfunction

    function automatic void queue_palette(logic [7:0] slot, logic [23:0] rgb);
        stream_item_t item;
        item.action = ACT_PALETTE;
        item.slot = slot;
        item.rgb = rgb;
        item.data = 8'($urandom);
        stream_items.push_back(item);
    endfunction

    function automatic void queue_word(logic [31:0] bytes);
        queue_byte(bytes[31:24]);
        queue_byte(bytes[23:16]);
        queue_byte(bytes[15:8]);
        queue_byte(bytes[7:0]);
    endfunction

    task automatic drain_pixels();
        int waited;
        waited = 0;
        while (pixels_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pixels_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d pixels never arrived", pixels_due.size()));
            pixels_due.delete();
        end
    endtask

    task automatic settle();
        while (stream_items.size() != 0 || in_valid)
            @(posedge clk);
        drain_pixels();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_IMAGE_WIDTH:   shadow_width = value[12:0];
            CFG_IMAGE_HEIGHT:  shadow_height = value[12:0];
            CFG_DEPTH_MODE:    shadow_mode = value[2:0];
            CFG_ROWS_TOP_DOWN: shadow_top_down = value[0];
            CFG_PALETTE_COUNT: shadow_count = value[8:0];
            default:           ;
        endcase
    endtask

    task automatic set_config(int w, int h, logic [2:0] mode, logic top_down, int count);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_DEPTH_MODE, int'(mode));
        write_reg(CFG_ROWS_TOP_DOWN, int'(top_down));
        write_reg(CFG_PALETTE_COUNT, count);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // sender: bursts of transactions separated by random gaps
    always @(negedge clk)
    begin
        stream_item_t item;
        if (!(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (rst_n && !hold_sender && stream_items.size() > 0)
            begin
                item = stream_items.pop_front();
                {action, palette_slot, palette_rgb, data_byte} <= item;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    if (steady || $urandom_range(0, 2) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: ready most of the time, with occasional stalls
    always @(negedge clk)
    begin
        if (steady)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
        end
    end

    always @(posedge clk)
    begin
        pix_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixels_due.size() == 0)
                    report_mismatch($sformatf("pixel (%0d,%0d) with none outstanding",
                                              pixel_x, pixel_y));
                else
                begin
                    want = pixels_due.pop_front();
                    check_field("pixel_x", pixel_x, want.x);
                    check_field("pixel_y", pixel_y, want.y);
                    check_field("red", red, want.argb[23:16]);
                    check_field("green", green, want.argb[15:8]);
                    check_field("blue", blue, want.argb[7:0]);
                    check_field("alpha", alpha, want.argb[31:24]);
                    check_field("last_of_byte", last_of_byte, want.last);
                    check_field("image_done", image_done, want.done);
                end
            end
            if (in_valid && in_ready)
                unpack_item({action, palette_slot, palette_rgb, data_byte});
            in_taken <= in_valid && in_ready;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int         fed;
        int         total;
        int         w;
        int         h;
        int         pick;
        int         row_len;
        logic [2:0] mode;
        logic       hold_used;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the whole palette so that no lookup hits an unwritten entry
        for (int s = 0; s < 256; s++)
            queue_palette(8'(s), (s == 0) ? 24'h000000 :
                                 (s == 255) ? 24'hFFFFFF : 24'($urandom));

        set_config(4, 1, DEPTH_8BPP, 1'b0, 256);
        queue_word(32'h00FF_807F);
        set_config(3, 1, DEPTH_4BPP, 1'b0, 3);
        queue_word(32'h12F0_AA55);
        set_config(9, 1, DEPTH_1BPP, 1'b1, 2);
        queue_word(32'hA580_C33C);
        set_config(2, 1, DEPTH_16BPP, 1'b0, 0);
        queue_word(32'hFF7F_2184);
        set_config(1, 1, DEPTH_24BPP, 1'b1, 0);
        queue_word(32'h0102_03EE);
        set_config(1, 1, DEPTH_32BPP, 1'b0, 0);
        queue_word(32'h1020_3040);
        set_config(1, 1, DEPTH_UNSUPPORTED, 1'b0, 0);
        queue_word(32'h5A00_00FF);

        fed = 0;
        hold_used = 1'b0;
        while (fed < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            w = (pick == 0) ? 0 : (pick == 1) ? 8191 : (pick == 2) ? 4096 :
                $urandom_range(1, 10);
            pick = $urandom_range(0, 9);
            h = (pick == 0) ? 0 : (pick == 1) ? 8191 : (pick == 2) ? 4096 :
                $urandom_range(1, 3);
            mode = 3'($urandom_range(0, 7));
            pick = $urandom_range(0, 5);
            set_config(w, h, mode, 1'($urandom),
                       (pick == 0) ? 0 : (pick == 1) ? 511 : (pick == 2) ? 256 :
                       $urandom_range(0, 300));
            @(posedge clk);
            steady = ($urandom_range(0, 3) == 0);

            row_len = ((clamp_size(13'(w)) * bits_per_pixel(mode) + 31) / 32) * 4;
            total = row_len * clamp_size(13'(h));
            if (total > 160)
                total = $urandom_range(4, 60);
            pick = $urandom_range(0, 5);
            if (pick == 0)
                total = total + $urandom_range(1, 5);
            else if (pick == 1 && total > 4)
                total = total - $urandom_range(1, 3);

            for (int i = 0; i < total; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    queue_palette(8'($urandom), 24'($urandom));
                queue_byte(8'($urandom));
            end
            fed = fed + total;

            if (!hold_used || $urandom_range(0, 3) == 0)
            begin
                while (stream_items.size() > total / 2)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid)
                    @(posedge clk);
                drain_pixels();
                @(posedge clk);
                hold_sender = 1'b0;
                hold_used = 1'b1;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/bpu_pkg.sv
design/bpu_ram.sv
design/bitmap_pixel_unpacker_unit.sv
design/bpu_checker.sv
bench/bitmap_pixel_unpacker_unit_test.sv
